// File: hw/rtl/arp_range_responder_top_defines.svh
// assertion macros for the arp range responder
`ifndef ARP_RANGE_RESPONDER_TOP_DEFINES_SVH
`define ARP_RANGE_RESPONDER_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define ARPR_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define ARPR_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: hw/rtl/arpr_pkg.sv
package arpr_pkg;

  // frame layout and protocol codes
  localparam int unsigned FRAME_LEN = 42;
  localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
  localparam logic [15:0] HW_ETHER = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [7:0] HW_ADDR_LEN = 8'd6;
  localparam logic [7:0] PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] OP_REQUEST = 16'h0001;
  localparam logic [15:0] OP_REPLY = 16'h0002;

  // pending job queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_ADDR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVING_MODE = 3'd4;

  localparam logic [5:0] PREFIX_RESET = 6'd32;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] base_addr;
    logic [5:0]  prefix_len;
    logic [31:0] probe_addr;
    logic        serving_mode;
  } cfg_t;

  // one unit of work for the emitter: a reply frame or a conflict event
  typedef struct packed {
    logic        is_conflict;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } job_t;

  typedef struct packed {
    logic push;
    logic conflict_seen;
  } front_stat_t;

endpackage

// File: hw/rtl/arpr_in_if.sv
interface arpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  logic       frame_truncated;

  modport source (output valid, rx_byte, frame_end, frame_truncated, input ready);
  modport sink (input valid, rx_byte, frame_end, frame_truncated, output ready);
endinterface

// File: hw/rtl/arpr_out_if.sv
interface arpr_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, out_kind, tx_byte, tx_last, input ready);
  modport sink (input valid, out_kind, tx_byte, tx_last, output ready);
endinterface

// File: hw/rtl/arpr_front.sv
module arpr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  arpr_in_if.sink              in_ch,
  input  arpr_pkg::cfg_t       cfg,
  input  logic                 q_full,
  output arpr_pkg::job_t       job,
  output arpr_pkg::front_stat_t stat
);
  import arpr_pkg::*;

  localparam logic [5:0] LAST_IDX = 6'(FRAME_LEN - 1);
  localparam logic [5:0] SAT_IDX = 6'(FRAME_LEN);

  logic [5:0]  idx_r, idx_nxt;
  logic [15:0] ether_r, ether_nxt;
  logic [15:0] hw_r, hw_nxt;
  logic [15:0] proto_r, proto_nxt;
  logic [7:0]  hlen_r, hlen_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [15:0] op_r, op_nxt;
  logic [47:0] smac_r, smac_nxt;
  logic [31:0] sip_r, sip_nxt;
  logic [31:0] tip_r, tip_nxt;
  logic        seen_r, seen_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        long_enough;
  logic        frame_ok;
  logic [5:0]  pl;
  logic [31:0] mask;
  logic [31:0] hi;
  logic        in_range;
  logic        want_reply;
  logic        want_conflict;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign b = in_ch.rx_byte;

  // capture header fields by byte position
  always_comb begin
    ether_nxt = ether_r;
    hw_nxt    = hw_r;
    proto_nxt = proto_r;
    hlen_nxt  = hlen_r;
    plen_nxt  = plen_r;
    op_nxt    = op_r;
    smac_nxt  = smac_r;
    sip_nxt   = sip_r;
    tip_nxt   = tip_r;
    if (idx_r < SAT_IDX) begin
      priority if (idx_r == 6'd12 || idx_r == 6'd13) begin
        ether_nxt = {ether_r[7:0], b};
      end else if (idx_r == 6'd14 || idx_r == 6'd15) begin
        hw_nxt = {hw_r[7:0], b};
      end else if (idx_r == 6'd16 || idx_r == 6'd17) begin
        proto_nxt = {proto_r[7:0], b};
      end else if (idx_r == 6'd18) begin
        hlen_nxt = b;
      end else if (idx_r == 6'd19) begin
        plen_nxt = b;
      end else if (idx_r == 6'd20 || idx_r == 6'd21) begin
        op_nxt = {op_r[7:0], b};
      end else if (idx_r >= 6'd22 && idx_r <= 6'd27) begin
        smac_nxt = {smac_r[39:0], b};
      end else if (idx_r >= 6'd28 && idx_r <= 6'd31) begin
        sip_nxt = {sip_r[23:0], b};
      end else if (idx_r >= 6'd38 && idx_r <= 6'd41) begin
        tip_nxt = {tip_r[23:0], b};
      end else begin
        ether_nxt = ether_r;
      end
    end
  end

  // address block bounds
  always_comb begin
    pl = (cfg.prefix_len > 6'd32) ? 6'd32 : cfg.prefix_len;
    mask = (pl == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - pl));
    hi = cfg.base_addr | ~mask;
    in_range = (cfg.base_addr <= tip_nxt) && (tip_nxt <= hi);
  end

  // frame check on the last word
  always_comb begin
    long_enough = (idx_r >= LAST_IDX);
    frame_ok = !in_ch.frame_truncated && long_enough &&
               ether_nxt == ETH_TYPE_ARP && hw_nxt == HW_ETHER &&
               proto_nxt == PROTO_IPV4 && hlen_nxt == HW_ADDR_LEN &&
               plen_nxt == PROTO_ADDR_LEN;
    want_reply = accept && in_ch.frame_end && frame_ok && op_nxt == OP_REQUEST &&
                 cfg.serving_mode && in_range;
    want_conflict = accept && in_ch.frame_end && frame_ok && op_nxt == OP_REPLY &&
                    !cfg.serving_mode && !seen_r && sip_nxt == cfg.probe_addr;
  end

  // position counter and sticky conflict flag
  always_comb begin
    idx_nxt = idx_r;
    seen_nxt = seen_r;
    if (accept) begin
      if (in_ch.frame_end) begin
        idx_nxt = 6'd0;
      end else if (idx_r < SAT_IDX) begin
        idx_nxt = idx_r + 6'd1;
      end
      if (want_conflict) begin
        seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 6'd0;
      seen_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      seen_r <= seen_nxt;
    end
  end

  // field capture registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ether_r <= ether_nxt;
      hw_r    <= hw_nxt;
      proto_r <= proto_nxt;
      hlen_r  <= hlen_nxt;
      plen_r  <= plen_nxt;
      op_r    <= op_nxt;
      smac_r  <= smac_nxt;
      sip_r   <= sip_nxt;
      tip_r   <= tip_nxt;
    end
  end

  assign job.is_conflict = want_conflict;
  assign job.sender_mac  = smac_nxt;
  assign job.sender_ip   = sip_nxt;
  assign job.target_ip   = tip_nxt;

  assign stat.push = want_reply || want_conflict;
  assign stat.conflict_seen = seen_r;
endmodule

// File: hw/rtl/arpr_queue.sv
module arpr_queue #(
  parameter int unsigned DEPTH = arpr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  arpr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output arpr_pkg::job_t head,
  output logic           empty
);
  import arpr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots_r[rd_r];

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_job;
    end
  end
endmodule

// File: hw/rtl/arpr_back.sv
module arpr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  arpr_pkg::cfg_t cfg,
  input  arpr_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  arpr_out_if.source     out_ch
);
  import arpr_pkg::*;

  localparam logic [5:0] LAST_IDX = 6'(FRAME_LEN - 1);
  localparam int unsigned FRAME_BITS = FRAME_LEN * 8;

  logic [5:0]            k_r, k_nxt;
  logic                  valid_r, valid_nxt;
  logic                  kind_r;
  logic [7:0]            byte_r;
  logic                  last_r;
  logic                  load;
  logic [FRAME_BITS-1:0] frame;
  logic [8:0]            bit_hi;
  logic [7:0]            cur_byte;
  logic                  cur_last;

  // reply frame in wire order, first word in the top bits
  assign frame = {head.sender_mac, cfg.own_mac, ETH_TYPE_ARP, HW_ETHER, PROTO_IPV4,
                  HW_ADDR_LEN, PROTO_ADDR_LEN, OP_REPLY, cfg.own_mac, head.target_ip,
                  head.sender_mac, head.sender_ip};

  assign bit_hi = 9'(FRAME_BITS - 1) - {k_r, 3'b000};
  assign cur_byte = head.is_conflict ? 8'h00 : frame[bit_hi -: 8];
  assign cur_last = head.is_conflict || (k_r == LAST_IDX);

  assign load = !empty && (!valid_r || out_ch.ready);
  assign pop = load && cur_last;

  // word counter and output valid
  always_comb begin
    k_nxt = k_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      k_nxt = cur_last ? 6'd0 : k_r + 6'd1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= 6'd0;
      valid_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head.is_conflict;
      byte_r <= cur_byte;
      last_r <= cur_last;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.out_kind = kind_r;
  assign out_ch.tx_byte  = byte_r;
  assign out_ch.tx_last  = last_r;
endmodule

// File: hw/rtl/arp_range_responder_top.sv
// ARP responder for IPv4 over Ethernet. Received frame bytes enter one word
// per clock on in_ch; the frame parser checks each frame at its last byte and
// queues a job for every accepted request in the claimed address block
// (serving mode) or for the first matching reply to probe_addr (probe mode).
// The emitter drains the queue at one output word per clock while out_ch is
// ready: a reply is 42 words, a conflict event one. Input takes one byte per
// cycle, stalling only while the queue holds QUEUE_DEPTH jobs; the emitter
// sets the sustained rate when replies come faster than one per 42 received
// bytes. The user must write configuration (cfg_we/cfg_index/cfg_data) only
// while idle, unenforced by the block; the conflict flag clears only on reset.
`include "arp_range_responder_top_defines.svh"

module arp_range_responder_top #(
  parameter int unsigned QUEUE_DEPTH = arpr_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  arpr_in_if.sink                         in_ch,
  arpr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arpr_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  job_t        push_job;
  job_t        head;
  front_stat_t fstat;
  logic        q_full;
  logic        q_empty;
  logic        pop;

  // configuration register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_MAC:      cfg_nxt.own_mac = cfg_data[47:0];
        CFG_BASE_ADDR:    cfg_nxt.base_addr = cfg_data[31:0];
        CFG_PREFIX_LEN:   cfg_nxt.prefix_len = cfg_data[5:0];
        CFG_PROBE_ADDR:   cfg_nxt.probe_addr = cfg_data[31:0];
        CFG_SERVING_MODE: cfg_nxt.serving_mode = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_mac      <= 48'h0;
      cfg_r.base_addr    <= 32'h0;
      cfg_r.prefix_len   <= PREFIX_RESET;
      cfg_r.probe_addr   <= 32'h0;
      cfg_r.serving_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  arpr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .job    (push_job),
    .stat   (fstat)
  );

  arpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fstat.push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  arpr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // queue never overflows or underflows
  `ARPR_ASSERT_IMPL(a_no_push_full, fstat.push, !q_full, "job pushed into full queue")
  `ARPR_ASSERT_IMPL(a_no_pop_empty, pop, !q_empty, "job popped from empty queue")
  // conflict event raised at most once
  `ARPR_ASSERT_IMPL(a_conflict_once, fstat.push && push_job.is_conflict,
                    !fstat.conflict_seen, "second conflict event queued")
  // conflict event word shape
  `ARPR_ASSERT_HOLD(a_conflict_word,
                    !(out_ch.valid && out_ch.out_kind) ||
                    (out_ch.tx_last && out_ch.tx_byte == 8'h00),
                    "malformed conflict event word")
endmodule
